FILE: design/quadratic_probe_hash_table_unit_defines.svh
// Assertion macros shared by the hash table unit modules.
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent.
`define QPHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpht: same-cycle check failed");
// Consequent checked in the cycle after the antecedent.
`define QPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpht: next-cycle check failed");
`else
`define QPHT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/qpht_pkg.sv
// Shared types and constants of the quadratic probe hash table unit.
package qpht_pkg;

    localparam int CMD_W      = 2;
    localparam int KEY_W      = 16;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int MARK_W     = 2;
    localparam int CFG_W      = 7;
    localparam int SIZE_W     = 7;
    localparam int LIVE_W     = 7;
    localparam int HASH_W     = 17;
    localparam int HASH_CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE = 2'd2;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value_out;
        logic              over_load;
    } t_result;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_slot;

    typedef struct packed {
        logic load;
        logic probe_init;
        logic probe_run;
        logic commit;
        logic clear;
    } t_dp_ctl;

    typedef struct packed {
        logic rem_done;
        logic hit;
        logic miss;
        logic is_nop;
        logic clear_done;
    } t_dp_stat;

endpackage

FILE: design/quadratic_probe_hash_table_unit.sv
// Top level of the quadratic probe hash table unit, whose receiver cannot stall results.
// One command at a time, paced by the 17-step hash remainder and one slot read per probe;
// command 3 skips the probe walk. Busy falls with the result strobe, so the next command
// can start in that cycle. Synchronous reset sets a table size of 4 and starts a pass that
// clears every slot mark, with busy high.
module quadratic_probe_hash_table_unit
    import qpht_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_valid,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // The controller sequences the work; the datapath holds all storage.
    // A command transfer happens when start is high while busy is low. The
    // datapath then reduces the key hash modulo the table size one bit per
    // cycle, walks the quadratic probe sequence with one slot read per cycle,
    // and on the first qualifying slot (or after the last probe) commits the
    // slot update, the live count and the result word in a single cycle.
    t_dp_ctl  ctl;
    t_dp_stat stat;

    qpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // The result is held on o_result for the single cycle in which o_valid
    // is high; that cycle's closing edge is the result transfer.
    qpht_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

FILE: design/qpht_rem.sv
// Bit-serial remainder unit that reduces the key hash modulo the table size.
module qpht_rem
    import qpht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SIZE_W-1:0] o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [HASH_CNT_W-1:0] r_cnt;
    logic [HASH_W-1:0]     r_dvd;
    logic [SIZE_W-1:0]     r_rem;
    logic [SIZE_W-1:0]     r_div;
    logic [SIZE_W:0]       trial;
    logic [SIZE_W-1:0]     n_rem;

    // One dividend bit per cycle; the partial remainder stays below the divisor.
    always_comb begin
        trial = {r_rem, r_dvd[HASH_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = SIZE_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == HASH_CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: design/qpht_dp.sv
// Datapath: size register, hash reduction, probe sequence, slot memory and result.
`include "quadratic_probe_hash_table_unit_defines.svh"
module qpht_dp
    import qpht_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_dp_ctl          i_ctl,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    output t_result          o_result
);

    localparam int AW       = $clog2(MAX_SLOTS);
    localparam int SIZE_CAP = (MAX_SLOTS < (2 ** SIZE_W) - 1) ? MAX_SLOTS : (2 ** SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP_V = SIZE_W'(SIZE_CAP);
    localparam logic [LIVE_W-1:0] LIVE_CAP_V = LIVE_W'(SIZE_CAP);
    localparam logic [AW-1:0]     LAST_ADDR  = AW'(MAX_SLOTS - 1);

    function automatic logic [SIZE_W-1:0] wrap_inc(input logic [SIZE_W-1:0] x,
                                                   input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] y;
        y = x + 1'b1;
        return (y == m) ? '0 : y;
    endfunction

    logic [CFG_W-1:0]  r_size_cfg;
    logic [SIZE_W-1:0] eff_size;
    logic [HASH_W-1:0] hash;

    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [SIZE_W-1:0] r_size;

    logic              rem_done;
    logic [SIZE_W-1:0] rem;

    logic [SIZE_W-1:0] r_pos;
    logic [SIZE_W-1:0] r_d;
    logic [SIZE_W-1:0] r_issued;
    logic [SIZE_W-1:0] r_pend_pos;
    logic              r_pend_v;
    logic [SIZE_W:0]   pos_sum;
    logic [SIZE_W-1:0] n_pos;
    logic [SIZE_W-1:0] n_d;
    logic              can_issue;

    t_slot             r_mem [MAX_SLOTS];
    t_slot             r_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_slot             mem_wd;
    logic [AW-1:0]     r_clr_addr;

    logic              match;
    logic              hit;
    logic              miss;
    logic [LIVE_W-1:0] r_live;
    logic [LIVE_W-1:0] n_live;
    logic [LIVE_W+1:0] four_live;
    logic [SIZE_W+1:0] three_size;
    logic              r_out_v;
    t_result           r_result;
    t_result           n_result;

    // Configuration register and its clamp to the usable range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_cfg <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size_cfg <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_size_cfg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_size_cfg > SIZE_CAP_V) begin
            eff_size = SIZE_CAP_V;
        end else begin
            eff_size = r_size_cfg;
        end
    end

    assign hash = ({1'b0, i_item.key} << 1) | HASH_W'(i_item.key >> 5);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_item.command;
            r_key  <= i_item.key;
            r_val  <= i_item.value;
            r_size <= eff_size;
        end
    end

    qpht_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.load),
        .i_dividend (hash),
        .i_divisor  (eff_size),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    // Probe i+1 sits 2i+1 past probe i, so position and step both advance
    // with a compare and subtract.
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_d};
        if (pos_sum >= {1'b0, r_size}) begin
            n_pos = SIZE_W'(pos_sum - {1'b0, r_size});
        end else begin
            n_pos = pos_sum[SIZE_W-1:0];
        end
        n_d = wrap_inc(wrap_inc(r_d, r_size), r_size);
    end

    assign can_issue = i_ctl.probe_run && (r_issued < r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_ctl.probe_init) begin
            r_pend_v <= 1'b0;
        end else begin
            r_pend_v <= can_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.probe_init) begin
            r_pos    <= rem;
            r_d      <= (r_size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
            r_issued <= '0;
        end else if (can_issue) begin
            r_pend_pos <= r_pos;
            r_pos      <= n_pos;
            r_d        <= n_d;
            r_issued   <= r_issued + 1'b1;
        end
    end

    // Check the slot read in the previous cycle.
    always_comb begin
        if (r_cmd == CMD_INSERT) begin
            match = (r_rd.mark == MARK_FREE);
        end else begin
            match = (r_rd.mark == MARK_LIVE) && (r_rd.key == r_key);
        end
        hit  = r_pend_v && match;
        miss = r_pend_v && !match && (r_issued == r_size);
    end

    // Slot memory: one write port shared by the clearing pass and commits.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_pend_pos);
        mem_wd = r_rd;
        if (i_ctl.clear) begin
            mem_we      = 1'b1;
            mem_wa      = r_clr_addr;
            mem_wd.mark = MARK_FREE;
        end else if (i_ctl.commit && hit) begin
            if (r_cmd == CMD_INSERT) begin
                mem_we       = 1'b1;
                mem_wd.mark  = MARK_LIVE;
                mem_wd.key   = r_key;
                mem_wd.value = r_val;
            end else if (r_cmd == CMD_DELETE) begin
                mem_we      = 1'b1;
                mem_wd.mark = MARK_GONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[AW'(r_pos)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Live count and result word.
    always_comb begin
        n_live = r_live;
        if (hit && (r_cmd == CMD_INSERT)) begin
            n_live = r_live + 1'b1;
        end else if (hit && (r_cmd == CMD_DELETE) && (r_live != '0)) begin
            n_live = r_live - 1'b1;
        end
        four_live  = {n_live, 2'b00};
        three_size = {1'b0, r_size, 1'b0} + {2'b00, r_size};

        n_result.over_load = (four_live > three_size);
        n_result.value_out = '0;
        if (r_cmd == CMD_NOP || hit) begin
            n_result.status = STAT_OK;
        end else if (r_cmd == CMD_INSERT) begin
            n_result.status = STAT_FULL;
        end else begin
            n_result.status = STAT_NOT_FOUND;
        end
        if (hit && (r_cmd == CMD_LOOKUP)) begin
            n_result.value_out = r_rd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= i_ctl.commit;
            if (i_ctl.commit) begin
                r_live <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_result <= n_result;
        end
    end

    assign o_stat.rem_done   = rem_done;
    assign o_stat.hit        = hit;
    assign o_stat.miss       = miss;
    assign o_stat.is_nop     = (r_cmd == CMD_NOP);
    assign o_stat.clear_done = (r_clr_addr == LAST_ADDR);
    assign o_valid           = r_out_v;
    assign o_result          = r_result;

    `QPHT_ASSERT_SAME(a_probe_in_range, i_clk, i_rst_n, i_ctl.probe_run, (r_pos < r_size) && (r_d < r_size))
    `QPHT_ASSERT_SAME(a_pend_counted, i_clk, i_rst_n, r_pend_v, (r_issued != '0) && (r_issued <= r_size))
    `QPHT_ASSERT_SAME(a_live_cap, i_clk, i_rst_n, 1'b1, r_live <= LIVE_CAP_V)

endmodule

FILE: design/qpht_ctrl.sv
// Controller: clearing pass, hash reduction wait, probe loop and commit.
`include "quadratic_probe_hash_table_unit_defines.svh"
module qpht_ctrl
    import qpht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl,
    output logic     o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_HASH  = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.rem_done) begin
                    if (i_stat.is_nop) begin
                        o_ctl.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_ctl.probe_init = 1'b1;
                        n_state          = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (i_stat.hit || i_stat.miss) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.probe_run = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `QPHT_ASSERT_SAME(a_commit_state, i_clk, i_rst_n, o_ctl.commit, (r_state == S_HASH) || (r_state == S_PROBE))
    `QPHT_ASSERT_NEXT(a_load_to_hash, i_clk, i_rst_n, o_ctl.load, (r_state == S_HASH) && o_busy)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the quadratic probe hash table unit.
`timescale 1ns / 100ps

module tb;
    import qpht_pkg::*;

    // Slot storage depth of the instance under test.
    localparam int TABLE_DEPTH = 64;

    // The run ends here at the latest. The slowest correct run needs about
    // 1350 transfers, and this limit is several times what they take.
    localparam int RUN_LIMIT_NS = 6_000_000;

    // Cycles to wait after the last result.
    localparam int SETTLE_CYCLES = 100;

    localparam int RANDOM_PER_PHASE = 80;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_valid;
    t_result          o_result;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    // Scoreboard. It keeps its own copy of the slot marks, keys, values,
    // live count and table size register, predicts the result of every
    // accepted command, and checks the results in order.
    class hash_table_scoreboard;
        logic [MARK_W-1:0] marks[TABLE_DEPTH];
        logic [KEY_W-1:0]  keys[TABLE_DEPTH];
        logic [VAL_W-1:0]  values[TABLE_DEPTH];
        int unsigned       live;
        logic [CFG_W-1:0]  size_reg;
        t_result           expected_results[$];
        int unsigned       mismatches;

        function new();
            foreach (marks[n]) begin
                marks[n]  = MARK_FREE;
                keys[n]   = '0;
                values[n] = '0;
            end
            live       = 0;
            size_reg   = CFG_SIZE_RESET;
            mismatches = 0;
        endfunction

        function void write_size(logic [CFG_W-1:0] v);
            size_reg = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // A size of zero acts as one, anything above the depth as the depth.
        function int unsigned active_slots();
            if (size_reg == 0) return 1;
            if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return 32'(size_reg);
        endfunction

        // First occupied slot along the probe sequence that holds the key,
        // or -1 when there is none.
        function int find_live(int unsigned h, logic [KEY_W-1:0] k, int unsigned sz);
            int          hit;
            int unsigned i;
            int unsigned s;
            hit = -1;
            for (i = 0; i < sz && hit < 0; i++) begin
                s = (h + i * i) % sz;
                if (marks[s] == MARK_LIVE && keys[s] == k) hit = s;
            end
            return hit;
        endfunction

        function void note_item(t_item it);
            t_result     r;
            int unsigned sz;
            int unsigned h;
            int unsigned i;
            int unsigned s;
            int unsigned k;
            int          hit;
            bit          placed;
            sz          = active_slots();
            k           = 32'(it.key);
            h           = (k << 1) | (k >> 5);
            r.status    = STAT_OK;
            r.value_out = '0;
            placed      = 1'b0;
            case (it.command)
                CMD_INSERT: begin
                    r.status = STAT_FULL;
                    for (i = 0; i < sz && !placed; i++) begin
                        s = (h + i * i) % sz;
                        if (marks[s] == MARK_FREE) begin
                            marks[s]  = MARK_LIVE;
                            keys[s]   = it.key;
                            values[s] = it.value;
                            live++;
                            r.status  = STAT_OK;
                            placed    = 1'b1;
                        end
                    end
                end
                CMD_DELETE: begin
                    hit = find_live(h, it.key, sz);
                    if (hit >= 0) begin
                        marks[hit] = MARK_GONE;
                        if (live > 0) live--;
                    end else begin
                        r.status = STAT_NOT_FOUND;
                    end
                end
                CMD_LOOKUP: begin
                    hit = find_live(h, it.key, sz);
                    if (hit >= 0) r.value_out = values[hit];
                    else r.status = STAT_NOT_FOUND;
                end
                default: begin
                end
            endcase
            r.over_load = (4 * live > 3 * sz);
            expected_results.push_back(r);
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result with no command pending: status %0d value %h",
                                     got.status, got.value_out));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.value_out !== want.value_out ||
                got.over_load !== want.over_load)
                flag_error($sformatf({"status exp %0d got %0d, value_out exp %h got %h, ",
                                      "over_load exp %0b got %0b"},
                                     want.status, got.status, want.value_out,
                                     got.value_out, want.over_load, got.over_load));
        endfunction
    endclass

    hash_table_scoreboard sb;

    // Keys that were recently inserted, so that lookups and deletes often hit.
    logic [KEY_W-1:0] key_pool[$];

    quadratic_probe_hash_table_unit #(
        .MAX_SLOTS(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor. It samples at the rising edge, before the block's own updates
    // land, so it sees the same values that the block acts on. A result and
    // a new transfer can share an edge; the result belongs to the older
    // command, and the queue keeps them in order either way.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_result);
            if (start && !busy) sb.note_item(i_item);
        end
    end

    // Present one command from the next falling edge and hold it until the
    // block takes the transfer. start stays high when transfers follow each
    // other, so it is never dropped and raised in the same step.
    task automatic send_item(t_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                            logic [VAL_W-1:0] v);
        t_item it;
        it.command = cmd;
        it.key     = k;
        it.value   = v;
        send_item(it);
    endtask

    // Leave start low for a number of cycles. The item bus carries noise
    // meanwhile, which the block must ignore.
    task automatic hold_off(int unsigned cycles);
        @(negedge i_clk);
        start  <= 1'b0;
        i_item <= t_item'({$urandom(), $urandom()});
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Every command answers, so the block is idle once the queue is empty.
    task automatic write_table_size(logic [CFG_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_size(v);
    endtask

    // Random command: mostly lookups and deletes of keys that were inserted
    // before, inserts of fresh or repeated keys, and now and then the unused
    // command code. Inserts are kept moderate, since slots are never reused.
    function automatic t_item next_random_item();
        t_item       it;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) it.command = CMD_INSERT;
        else if (roll < 65) it.command = CMD_LOOKUP;
        else if (roll < 93) it.command = CMD_DELETE;
        else it.command = CMD_NOP;
        if (key_pool.size() != 0 && $urandom_range(99) < 60)
            it.key = key_pool[$urandom_range(key_pool.size() - 1)];
        else
            it.key = KEY_W'($urandom());
        it.value = $urandom();
        if (it.command == CMD_INSERT) begin
            key_pool.push_back(it.key);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
        end
        return it;
    endfunction

    // Table sizes of the random phases. They mostly grow, so that later
    // phases still reach slots that were never used; the extremes and the
    // out-of-range codes come near the end.
    int unsigned phase_sizes[16] = '{2, 3, 5, 7, 8, 13, 16, 24, 32, 40, 48, 64,
                                     1, 127, 65, 100};

    initial begin
        bit quiet;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size of four slots. Send waits on busy,
        // so the slot clearing pass after reset is simply waited out.
        send_cmd(CMD_INSERT, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_cmd(CMD_LOOKUP, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(CMD_LOOKUP, 16'h1357, 32'h0000_0000);
        send_cmd(CMD_INSERT, 16'h0020, 32'hA5A5_A5A5);
        // A duplicate key is not checked for, but its probe sequence meets no free slot, so it reports full.
        send_cmd(CMD_INSERT, 16'h0000, 32'h5A5A_5A5A);
        send_cmd(CMD_LOOKUP, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_DELETE, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_DELETE, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_DELETE, 16'h0000, 32'h0000_0000);
        send_cmd(CMD_LOOKUP, 16'h0000, 32'h0000_0000);
        // The probe sequence of this key reaches only used or deleted slots, so the table reports full.
        send_cmd(CMD_INSERT, 16'h00FF, 32'h1234_5678);
        send_cmd(CMD_NOP,    16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_NOP,    16'h0000, 32'h0000_0000);

        // A size of zero acts as one slot. The slots keep their contents
        // across the change, and the load flag follows the new size.
        write_table_size(7'd0);
        send_cmd(CMD_INSERT, 16'h4444, 32'hDEAD_BEEF);
        send_cmd(CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
        send_cmd(CMD_DELETE, 16'hFFFF, 32'h0000_0000);
        send_cmd(CMD_NOP,    16'h4444, 32'h0000_0000);

        // A size above the depth acts as the full depth.
        write_table_size(7'd127);
        send_cmd(CMD_INSERT, 16'h0001, 32'hCAFE_F00D);
        send_cmd(CMD_LOOKUP, 16'h0001, 32'h0000_0000);
        send_cmd(CMD_DELETE, 16'h0001, 32'h0000_0000);

        // Random part, one phase per table size. Phases five to seven run
        // back to back with no gaps; in the middle of phase four the sender
        // waits until every result is home.
        foreach (phase_sizes[p]) begin
            write_table_size(CFG_W'(phase_sizes[p]));
            quiet = (p >= 5 && p <= 7);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == 4 && n == RANDOM_PER_PHASE / 2) drain();
                if (!quiet && $urandom_range(99) < 20) hold_off($urandom_range(1, 8));
                send_item(next_random_item());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake or results that never arrive.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
